>>> design/picd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picd_pkg - shared types and constants of the PI duty controller
// Field widths, configuration register codes and the queue entry format.
// ----------------------------------------------------------------------------
package picd_pkg;

    // Field widths
    localparam int SAMPLE_W = 10;    // measurement and setpoint
    localparam int GAIN_W   = 11;    // unsigned gain, 10 fraction bits
    localparam int LIMIT_W  = 15;    // integral magnitude bound
    localparam int ERR_W    = 11;    // signed setpoint - measurement
    localparam int SUM_W    = 16;    // signed integral
    localparam int DUTY_W   = 8;
    localparam int FRAC_W   = 10;    // gain scale is 2**FRAC_W

    // Products and their sum
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;    // 23
    localparam int PROD_I_W = GAIN_W + 1 + SUM_W;    // 28
    localparam int ACC_W    = PROD_I_W + 1;          // 29

    // Reset values of the configuration registers
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(1024);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2000);
    localparam logic [DUTY_W-1:0]  DUTY_MAX    = DUTY_W'(255);

    // Queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register index
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN = 2'd0,
        REG_INT_GAIN  = 2'd1,
        REG_INT_LIMIT = 2'd2
    } cfg_reg_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  int_gain;
        logic [LIMIT_W-1:0] int_limit;
    } cfg_t;

    // One classified item: error and the integral after this item
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [SUM_W-1:0] sum;
    } entry_t;

    // Queue status toward the front and the back
    typedef struct packed {
        logic full;
        logic nonempty;
    } queue_status_t;

endpackage

>>> design/picd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picd_front - input side of the PI duty controller
// Takes samples, forms the error and updates the clamped integral.
// ----------------------------------------------------------------------------
module picd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [picd_pkg::SAMPLE_W-1:0]       measurement,
    input  logic [picd_pkg::SAMPLE_W-1:0]       setpoint,
    input  picd_pkg::cfg_t                      cfg,
    input  picd_pkg::queue_status_t             qstat,
    output logic                                push,
    output picd_pkg::entry_t                    push_entry
);

    localparam int RAW_W = picd_pkg::SUM_W + 1;

    logic signed [picd_pkg::SUM_W-1:0] error_sum_reg;
    logic signed [picd_pkg::SUM_W-1:0] error_sum_next;
    logic signed [picd_pkg::ERR_W-1:0] err;
    logic signed [RAW_W-1:0]           sum_raw;
    logic signed [RAW_W-1:0]           lim_pos;
    logic signed [RAW_W-1:0]           lim_neg;
    logic                              accept;

    // Stall only when the queue has no room
    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full;

    // Error and raw sum at full width, so nothing wraps before the clamp
    assign err     = $signed({1'b0, setpoint}) - $signed({1'b0, measurement});
    assign sum_raw = RAW_W'(error_sum_reg) + RAW_W'(err);
    assign lim_pos = $signed({2'b00, cfg.int_limit});
    assign lim_neg = -lim_pos;

    // Clamp to +/- limit
    always_comb
    begin
        error_sum_next = error_sum_reg;
        if (accept)
        begin
            priority if (sum_raw > lim_pos)
                error_sum_next = lim_pos[picd_pkg::SUM_W-1:0];
            else if (sum_raw < lim_neg)
                error_sum_next = lim_neg[picd_pkg::SUM_W-1:0];
            else
                error_sum_next = sum_raw[picd_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            error_sum_reg <= '0;
        else
            error_sum_reg <= error_sum_next;
    end

    // Hand the classified item to the queue
    assign push           = accept;
    assign push_entry.err = err;
    assign push_entry.sum = error_sum_next;

endmodule

>>> design/picd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picd_queue - short queue between front and back
// Register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module picd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  picd_pkg::entry_t        push_entry,
    input  logic                    pop,
    output picd_pkg::entry_t        pop_entry,
    output picd_pkg::queue_status_t qstat
);

    picd_pkg::entry_t                mem_reg [picd_pkg::QUEUE_DEPTH];
    logic [picd_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [picd_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [picd_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [picd_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [picd_pkg::QCNT_W-1:0]     count_reg;
    logic [picd_pkg::QCNT_W-1:0]     count_next;
    logic                            do_push;
    logic                            do_pop;

    assign qstat.full     = (count_reg == picd_pkg::QCNT_W'(picd_pkg::QUEUE_DEPTH));
    assign qstat.nonempty = (count_reg != '0);
    assign do_push        = push && !qstat.full;
    assign do_pop         = pop && qstat.nonempty;
    assign pop_entry      = mem_reg[rd_ptr_reg];

    // Pointers wrap naturally at a power-of-two depth
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> design/picd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picd_back - execution side of the PI duty controller
// Gain products in one stage, scaling and saturation into the output register.
// ----------------------------------------------------------------------------
module picd_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  picd_pkg::cfg_t                   cfg,
    input  picd_pkg::queue_status_t          qstat,
    input  picd_pkg::entry_t                 pop_entry,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [picd_pkg::DUTY_W-1:0]      duty
);

    localparam int SAT_W = picd_pkg::ACC_W - picd_pkg::FRAC_W;

    // Product stage
    logic                                     prod_valid_reg;
    logic                                     prod_valid_next;
    logic signed [picd_pkg::PROD_P_W-1:0]     prod_p_reg;
    logic signed [picd_pkg::PROD_I_W-1:0]     prod_i_reg;
    // Output stage
    logic                                     out_valid_reg;
    logic                                     out_valid_next;
    logic [picd_pkg::DUTY_W-1:0]              duty_reg;
    logic [picd_pkg::DUTY_W-1:0]              duty_next;

    logic                                     out_load;
    logic                                     prod_load;
    logic signed [picd_pkg::ACC_W-1:0]        acc;
    logic [SAT_W-1:0]                         quot;

    // Flow control: each stage moves when the one after it has room
    assign out_load  = !out_valid_reg || !out_stall;
    assign prod_load = !prod_valid_reg || out_load;
    assign pop       = prod_load && qstat.nonempty;

    always_comb
    begin
        prod_valid_next = prod_valid_reg;
        if (prod_load)
            prod_valid_next = qstat.nonempty;
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = prod_valid_reg;
    end

    // Gain products, gains taken as unsigned
    always_ff @(posedge clk)
    begin
        if (prod_load)
        begin
            prod_p_reg <= $signed({1'b0, cfg.prop_gain}) * pop_entry.err;
            prod_i_reg <= $signed({1'b0, cfg.int_gain}) * pop_entry.sum;
        end
    end

    // Sum, divide by 1024 and saturate; a negative sum gives a duty of 0
    assign acc  = picd_pkg::ACC_W'(prod_p_reg) + picd_pkg::ACC_W'(prod_i_reg);
    assign quot = acc[picd_pkg::ACC_W-1:picd_pkg::FRAC_W];

    always_comb
    begin
        priority if (acc[picd_pkg::ACC_W-1])
            duty_next = '0;
        else if (quot >= SAT_W'(picd_pkg::DUTY_MAX))
            duty_next = picd_pkg::DUTY_MAX;
        else
            duty_next = quot[picd_pkg::DUTY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (out_load && prod_valid_reg)
            duty_reg <= duty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty      = duty_reg;

endmodule

>>> design/pi_controller_pwm_duty_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_controller_pwm_duty_core - PI controller with clamped integral
// Turns measurement/setpoint samples into an 8-bit PWM duty value.
// ----------------------------------------------------------------------------
//  channel | signals                                  | transfer when
//  --------+------------------------------------------+----------------------
//  in      | in_valid, in_stall, measurement, setpoint| in_valid && !in_stall
//  out     | out_valid, out_stall, duty               | out_valid && !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid && cfg_ready
//
//  One item per cycle sustained while out_stall is low; a result passes the
//  queue slot, the product register and the output register before it can
//  transfer.
//  Reset: integral 0, both gains 1024 (unity), integral limit 2000.
//  The front updates the integral as each item arrives; a 4-entry queue lets
//  the input keep flowing while out_stall holds the back, until it is full.
// ----------------------------------------------------------------------------
module pi_controller_pwm_duty_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [picd_pkg::SAMPLE_W-1:0]        measurement,
    input  logic [picd_pkg::SAMPLE_W-1:0]        setpoint,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [picd_pkg::DUTY_W-1:0]          duty,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [picd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [picd_pkg::LIMIT_W-1:0]         cfg_data
);

    picd_pkg::cfg_t                  cfg_reg;
    picd_pkg::cfg_t                  cfg_next;
    picd_pkg::queue_status_t         qstat;
    picd_pkg::entry_t                push_entry;
    picd_pkg::entry_t                pop_entry;
    logic                            push;
    logic                            pop;

    // Configuration registers; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (picd_pkg::cfg_reg_t'(cfg_index))
                picd_pkg::REG_PROP_GAIN: cfg_next.prop_gain = cfg_data[picd_pkg::GAIN_W-1:0];
                picd_pkg::REG_INT_GAIN:  cfg_next.int_gain  = cfg_data[picd_pkg::GAIN_W-1:0];
                picd_pkg::REG_INT_LIMIT: cfg_next.int_limit = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain <= picd_pkg::GAIN_RESET;
            cfg_reg.int_gain  <= picd_pkg::GAIN_RESET;
            cfg_reg.int_limit <= picd_pkg::LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: error and integral
    picd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .measurement(measurement),
        .setpoint   (setpoint),
        .cfg        (cfg_reg),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue between the two sides
    picd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .pop_entry (pop_entry),
        .qstat     (qstat)
    );

    // Back: gains, scaling, saturation
    picd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .qstat    (qstat),
        .pop_entry(pop_entry),
        .pop      (pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .duty     (duty)
    );

endmodule

>>> design/picd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picd_checker - port-level checks for the PI duty controller
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module picd_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [picd_pkg::DUTY_W-1:0]      duty,
    input  logic                             cfg_ready
);

    // A stalled result stays and keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(duty))
        else $error("stalled result changed or dropped");

    // With the output flowing, a result shows up after an input transfer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("result missing after input transfer");

    // The input side only backs up after the output side stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_stall))
        else $error("input stall without output stall");

    // Configuration writes are always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind pi_controller_pwm_duty_core picd_checker u_picd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .duty     (duty),
    .cfg_ready(cfg_ready)
);
